[src/tmrtab_pkg.sv]
// shared types and constants for the timer table
// no dependencies; used by every module of the block
package tmrtab_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ID_W        = 32;
  localparam int TICKS_W     = 32;
  localparam int IN_DATA_W   = 96;
  localparam int OUT_DATA_W  = 32;

  // input command codes
  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_ONCE     = 2'd1,
    CMD_PERIODIC = 2'd2,
    CMD_STOP     = 2'd3
  } cmd_t;

  // result word kinds
  typedef enum logic {
    EV_FIRED  = 1'b0,
    EV_REJECT = 1'b1
  } event_t;

  // one table entry
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TICKS_W-1:0] remaining;
    logic [TICKS_W-1:0] reload;
    logic               periodic;
    logic               stopped;
  } entry_t;

  // verdict of the tick unit for one entry
  typedef struct packed {
    logic               fire;
    logic               keep;
    logic [TICKS_W-1:0] next_rem;
  } tick_res_t;

endpackage

[src/tmrtab_store.sv]
// entry storage of the timer table: one write port, one registered read port
// depends on tmrtab_pkg
module tmrtab_store (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [tmrtab_pkg::IDX_W-1:0] wr_addr,
  input  tmrtab_pkg::entry_t      wr_entry,
  input  logic [tmrtab_pkg::IDX_W-1:0] rd_addr,
  output tmrtab_pkg::entry_t      rd_entry
);
  import tmrtab_pkg::*;

  entry_t slots [TABLE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_addr] <= wr_entry;
    end
  end

  // read port, registered: data in the cycle after the address
  always_ff @(posedge clk) begin
    rd_entry <= slots[rd_addr];
  end

endmodule

[src/tmrtab_unit.sv]
// shared tick unit: expiry compare, decrement and reload select for one entry
// depends on tmrtab_pkg
module tmrtab_unit (
  input  tmrtab_pkg::entry_t    entry,
  output tmrtab_pkg::tick_res_t res
);
  import tmrtab_pkg::*;

  logic expired;

  // count of 0 or 1 expires on this tick
  assign expired = (entry.remaining[TICKS_W-1:1] == '0);

  assign res.fire     = !entry.stopped && expired;
  assign res.keep     = !entry.stopped && (!expired || entry.periodic);
  assign res.next_rem = expired ? entry.reload : (entry.remaining - TICKS_W'(1));

endmodule

[src/one_shot_and_periodic_timer_table_top.sv]
// top level of the timer table: command sequencer and result register
// depends on tmrtab_pkg, tmrtab_store, tmrtab_unit
//
// usage:
// - in channel: in_tuser carries the command (tick, schedule once, schedule
//   periodic, stop by id); in_tdata carries task id, delay and interval
// - out channel: one word per fired task, or one reject word when an add
//   finds the table full; out_tlast marks the last word of a command
// - a schedule command is written straight from idle (a rejected one goes
//   through the flush state); a stop scans the table one entry a cycle
// - a tick walks the table one entry a cycle through the shared tick unit,
//   compacting removed entries in place, unless the walk pauses on a full
//   output, and ends by flushing the held word
// - in_tready is high only between commands; one command is worked at a time
// - a fired word is held one entry behind so that the last one can carry
//   tlast; when out_tready stays low the walk pauses at the next firing entry
// - reset empties the table (entry_count to zero) and drops pending words;
//   the entry storage itself is not cleared
module one_shot_and_periodic_timer_table_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tmrtab_pkg::IN_DATA_W-1:0]  in_tdata,   // task_id, delay_ticks, interval_ticks
  input  logic [1:0]                        in_tuser,   // command
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tmrtab_pkg::OUT_DATA_W-1:0] out_tdata,  // fired_id
  output logic                              out_tuser,  // event_kind
  output logic                              out_tlast   // last_event
);
  import tmrtab_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_STOP  = 4'b0010,
    ST_TICK  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   rd_r, rd_nxt;
  logic [CNT_W-1:0]   wr_r, wr_nxt;
  logic [ID_W-1:0]    stop_id_r, stop_id_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  logic [ID_W-1:0]    pend_id_r, pend_id_nxt;
  event_t             pend_kind_r, pend_kind_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]    out_id_r, out_id_nxt;
  event_t             out_kind_r, out_kind_nxt;
  logic               out_last_r, out_last_nxt;

  logic               st_wr_en;
  logic [IDX_W-1:0]   st_wr_addr;
  entry_t             st_wr_entry;
  entry_t             rd_entry;
  tick_res_t          tick_res;

  cmd_t               cmd;
  logic [ID_W-1:0]    in_id;
  logic [TICKS_W-1:0] in_delay;
  logic [TICKS_W-1:0] in_interval;
  logic               out_free;

  assign cmd         = cmd_t'(in_tuser);
  assign in_id       = in_tdata[ID_W-1:0];
  assign in_delay    = in_tdata[ID_W +: TICKS_W];
  assign in_interval = in_tdata[ID_W+TICKS_W +: TICKS_W];
  assign out_free    = !out_valid_r || out_tready;

  // entry storage, addressed with the next read index so data lines up with rd_r
  tmrtab_store u_store (
    .clk      (clk),
    .wr_en    (st_wr_en),
    .wr_addr  (st_wr_addr),
    .wr_entry (st_wr_entry),
    .rd_addr  (rd_nxt[IDX_W-1:0]),
    .rd_entry (rd_entry)
  );

  // shared tick unit
  tmrtab_unit u_unit (
    .entry (rd_entry),
    .res   (tick_res)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_nxt         = rd_r;
    wr_nxt         = wr_r;
    stop_id_nxt    = stop_id_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    pend_kind_nxt  = pend_kind_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_id_nxt     = out_id_r;
    out_kind_nxt   = out_kind_r;
    out_last_nxt   = out_last_r;
    st_wr_en       = 1'b0;
    st_wr_addr     = wr_r[IDX_W-1:0];
    st_wr_entry    = rd_entry;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          unique case (cmd)
            CMD_TICK: begin
              rd_nxt    = '0;
              wr_nxt    = '0;
              state_nxt = ST_TICK;
            end
            CMD_ONCE, CMD_PERIODIC: begin
              if (count_r == CNT_W'(TABLE_DEPTH)) begin
                pend_valid_nxt = 1'b1;
                pend_id_nxt    = in_id;
                pend_kind_nxt  = EV_REJECT;
                state_nxt      = ST_FLUSH;
              end else begin
                st_wr_en              = 1'b1;
                st_wr_addr            = count_r[IDX_W-1:0];
                st_wr_entry.id        = in_id;
                st_wr_entry.remaining = in_delay;
                st_wr_entry.reload    = (cmd == CMD_PERIODIC) ? in_interval : '0;
                st_wr_entry.periodic  = (cmd == CMD_PERIODIC);
                st_wr_entry.stopped   = 1'b0;
                count_nxt             = count_r + CNT_W'(1);
              end
            end
            CMD_STOP: begin
              stop_id_nxt = in_id;
              rd_nxt      = '0;
              state_nxt   = ST_STOP;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end

      // linear search for the first matching id
      ST_STOP: begin
        if (rd_r == count_r) begin
          state_nxt = ST_IDLE;
        end else if (rd_entry.id == stop_id_r) begin
          st_wr_en            = 1'b1;
          st_wr_addr          = rd_r[IDX_W-1:0];
          st_wr_entry.stopped = 1'b1;
          state_nxt           = ST_IDLE;
        end else begin
          rd_nxt = rd_r + CNT_W'(1);
        end
      end

      // walk entries, compacting survivors toward the front
      ST_TICK: begin
        if (rd_r == count_r) begin
          count_nxt = wr_r;
          state_nxt = ST_FLUSH;
        end else if (!(tick_res.fire && pend_valid_r && !out_free)) begin
          if (tick_res.keep) begin
            st_wr_en              = 1'b1;
            st_wr_addr            = wr_r[IDX_W-1:0];
            st_wr_entry.remaining = tick_res.next_rem;
            wr_nxt                = wr_r + CNT_W'(1);
          end
          rd_nxt = rd_r + CNT_W'(1);
          if (tick_res.fire) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_id_nxt    = pend_id_r;
              out_kind_nxt  = pend_kind_r;
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_id_nxt    = rd_entry.id;
            pend_kind_nxt  = EV_FIRED;
          end
        end
      end

      // send the held word with tlast
      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_id_nxt     = pend_id_r;
          out_kind_nxt   = pend_kind_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_r        <= rd_nxt;
    wr_r        <= wr_nxt;
    stop_id_r   <= stop_id_nxt;
    pend_id_r   <= pend_id_nxt;
    pend_kind_r <= pend_kind_nxt;
    out_id_r    <= out_id_nxt;
    out_kind_r  <= out_kind_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_id_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule
